### hw/rtl/packet_buffer_first_fit_allocator_macros.svh
// assertion macros for the packet buffer allocator checker
// used by pbfa_checker.sv only, no other dependencies
`ifndef PACKET_BUFFER_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PACKET_BUFFER_FIRST_FIT_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PBFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PBFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pbfa_pkg.sv
// shared types and codes for the packet buffer first-fit allocator
// no dependencies
package pbfa_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_REALLOC  = 2'd2,
        REQ_CONTAINS = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIZE   = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        WSEL_VIEW = 2'd0,
        WSEL_NEW  = 2'd1,
        WSEL_PAY  = 2'd2
    } t_wsel;

    typedef enum logic [1:0] {
        ROFF_HDR = 2'd0,
        ROFF_NEW = 2'd1,
        ROFF_TGT = 2'd2
    } t_roff_sel;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] req_size;
        logic [11:0] target_offset;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] result_offset;
        logic        copy_needed;
        logic [11:0] copy_source;
        logic        in_buffer;
    } t_res_item;

    // controller to datapath
    typedef struct packed {
        logic      load_req;
        logic      prev_load;
        logic      ra_load;
        logic      head_set;
        logic      head_clr;
        logic      mem_wr;
        t_wsel     wsel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      st_ld;
        t_status   st_code;
        logic      roff_ld;
        t_roff_sel roff_sel;
        logic      copy_set;
        logic      out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       bad;
        logic       tgt_zero;
        logic       head_empty;
        logic       loc_match;
        logic       gap_fit;
        logic       end_fit;
        logic       ra_inplace;
    } t_stat;

endpackage

### hw/rtl/pbfa_ctl.sv
// sequencer for the allocator: table walks, shifts and result hand-off
// depends on pbfa_pkg
module pbfa_ctl #(
    parameter int MAX_CHUNKS = 32,
    localparam int CW = $clog2(MAX_CHUNKS + 1),
    localparam int IW = $clog2(MAX_CHUNKS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pbfa_pkg::t_stat  i_st,
    input  logic [CW-1:0]    i_count,
    output pbfa_pkg::t_cmd   o_cmd,
    output logic [CW-1:0]    o_idx,
    output logic [IW-1:0]    o_rd_addr,
    output logic [IW-1:0]    o_wr_addr
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISP     = 9'b000000010,
        S_LOC      = 9'b000000100,
        S_FIT      = 9'b000001000,
        S_FIT_END  = 9'b000010000,
        S_SHIFT_UP = 9'b000100000,
        S_INSERT   = 9'b001000000,
        S_DROP     = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_hit, n_hit;
    logic [CW-1:0] r_gap, n_gap;
    logic          r_second, n_second;
    logic          r_out_valid, n_out_valid;
    logic          r_ra_chk, n_ra_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_hit       <= '0;
            r_gap       <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ra_chk    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_hit       <= n_hit;
            r_gap       <= n_gap;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
            r_ra_chk    <= n_ra_chk;
        end
    end

    always_comb begin
        logic          found;
        logic [CW-1:0] g;
        logic          post_alloc;
        found       = 1'b0;
        g           = '0;
        post_alloc  = 1'b0;
        n_state     = r_state;
        n_i         = r_i;
        n_hit       = r_hit;
        n_gap       = r_gap;
        n_second    = r_second;
        n_ra_chk    = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_wr_addr   = '0;

        if (r_ra_chk) begin
            // realloc: hit entry captured, r_i points at the following entry
            if (i_st.ra_inplace) begin
                if (r_hit == '0) begin
                    o_cmd.head_set = 1'b1;
                end else begin
                    o_cmd.mem_wr = 1'b1;
                    o_cmd.wsel   = pbfa_pkg::WSEL_PAY;
                    o_wr_addr    = r_hit[IW-1:0];
                end
                o_cmd.roff_ld  = 1'b1;
                o_cmd.roff_sel = pbfa_pkg::ROFF_TGT;
                n_state        = S_DONE;
            end else begin
                n_i     = '0;
                n_state = S_FIT;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.load_req = 1'b1;
                        n_state        = S_DISP;
                    end
                end
                S_DISP: begin
                    n_i      = '0;
                    n_second = 1'b0;
                    unique case (i_st.req_type)
                        pbfa_pkg::REQ_ALLOC: begin
                            if (i_st.bad) begin
                                o_cmd.st_ld   = 1'b1;
                                o_cmd.st_code = pbfa_pkg::ST_BAD_SIZE;
                                n_state       = S_DONE;
                            end else begin
                                n_state = S_FIT;
                            end
                        end
                        pbfa_pkg::REQ_FREE: begin
                            n_state = S_LOC;
                        end
                        pbfa_pkg::REQ_REALLOC: begin
                            if (i_st.bad) begin
                                o_cmd.st_ld   = 1'b1;
                                o_cmd.st_code = pbfa_pkg::ST_BAD_SIZE;
                                n_state       = S_DONE;
                            end else if (i_st.tgt_zero) begin
                                n_state = S_FIT;
                            end else begin
                                n_state = S_LOC;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
                S_LOC: begin
                    if (i_st.loc_match) begin
                        n_hit = r_i;
                        if (i_st.req_type == pbfa_pkg::REQ_REALLOC && !r_second) begin
                            o_cmd.ra_load = 1'b1;
                            n_i           = r_i + CW'(1);
                            n_ra_chk      = 1'b1;
                        end else if (r_i == '0) begin
                            o_cmd.head_clr = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            n_i     = r_i + CW'(1);
                            n_state = S_DROP;
                        end
                    end else if (r_i + CW'(1) >= i_count) begin
                        o_cmd.st_ld   = 1'b1;
                        o_cmd.st_code = pbfa_pkg::ST_NOT_FOUND;
                        n_state       = S_DONE;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
                S_FIT: begin
                    if (i_st.gap_fit) begin
                        found = 1'b1;
                        g     = r_i - CW'(1);
                    end else begin
                        o_cmd.prev_load = 1'b1;
                        if (r_i + CW'(1) >= i_count) begin
                            n_state = S_FIT_END;
                        end else begin
                            n_i = r_i + CW'(1);
                        end
                    end
                end
                S_FIT_END: begin
                    if (i_st.end_fit) begin
                        found = 1'b1;
                        g     = r_i;
                    end else begin
                        o_cmd.st_ld   = 1'b1;
                        o_cmd.st_code = pbfa_pkg::ST_NO_SPACE;
                        n_state       = S_DONE;
                    end
                end
                S_SHIFT_UP: begin
                    if (r_i > r_gap) begin
                        o_cmd.mem_wr = 1'b1;
                        o_cmd.wsel   = pbfa_pkg::WSEL_VIEW;
                        o_wr_addr    = IW'(r_i + CW'(1));
                    end
                    if (r_i > r_gap + CW'(1)) begin
                        n_i = r_i - CW'(1);
                    end else begin
                        n_state = S_INSERT;
                    end
                end
                S_INSERT: begin
                    o_cmd.mem_wr  = 1'b1;
                    o_cmd.wsel    = pbfa_pkg::WSEL_NEW;
                    o_wr_addr     = IW'(r_gap + CW'(1));
                    o_cmd.cnt_inc = 1'b1;
                    post_alloc    = 1'b1;
                end
                S_DROP: begin
                    if (r_i < i_count) begin
                        o_cmd.mem_wr = 1'b1;
                        o_cmd.wsel   = pbfa_pkg::WSEL_VIEW;
                        o_wr_addr    = IW'(r_i - CW'(1));
                        n_i          = r_i + CW'(1);
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end

        if (found) begin
            if (g == '0 && i_st.head_empty) begin
                o_cmd.head_set = 1'b1;
                o_cmd.roff_ld  = 1'b1;
                o_cmd.roff_sel = pbfa_pkg::ROFF_HDR;
                post_alloc     = 1'b1;
            end else if (i_count == CW'(MAX_CHUNKS)) begin
                o_cmd.st_ld   = 1'b1;
                o_cmd.st_code = pbfa_pkg::ST_TABLE_FULL;
                n_state       = S_DONE;
            end else begin
                n_gap          = g;
                o_cmd.roff_ld  = 1'b1;
                o_cmd.roff_sel = pbfa_pkg::ROFF_NEW;
                n_i            = i_count - CW'(1);
                n_state        = S_SHIFT_UP;
            end
        end

        if (post_alloc) begin
            if (i_st.req_type == pbfa_pkg::REQ_REALLOC && !i_st.tgt_zero) begin
                o_cmd.copy_set = 1'b1;
                n_second       = 1'b1;
                n_i            = '0;
                n_state        = S_LOC;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_idx       = r_i;
    assign o_rd_addr   = n_i[IW-1:0];

endmodule

### hw/rtl/pbfa_dp.sv
// datapath: chunk table memory, head entry, fit arithmetic, result registers
// depends on pbfa_pkg
module pbfa_dp #(
    parameter int BUF_BYTES  = 4096,
    parameter int HDR_BYTES  = 6,
    parameter int MAX_CHUNKS = 32,
    localparam int CW = $clog2(MAX_CHUNKS + 1),
    localparam int IW = $clog2(MAX_CHUNKS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pbfa_pkg::t_req_item  i_in,
    input  pbfa_pkg::t_cmd       i_cmd,
    input  logic [CW-1:0]        i_idx,
    input  logic [IW-1:0]        i_rd_addr,
    input  logic [IW-1:0]        i_wr_addr,
    output pbfa_pkg::t_stat      o_st,
    output logic [CW-1:0]        o_count,
    output pbfa_pkg::t_res_item  o_out
);

    localparam int SW = $clog2(BUF_BYTES);
    localparam int PW = $clog2(BUF_BYTES + 1);
    localparam int EW = PW + 1;
    localparam int XW = (EW > 12) ? EW : 12;

    logic [SW+PW-1:0] mem [MAX_CHUNKS];

    pbfa_pkg::t_req_item r_req;
    logic [PW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [SW+PW-1:0]    r_rd;
    logic [EW-1:0]       r_prev_end;
    logic [SW-1:0]       r_ra_st;
    logic [PW-1:0]       r_ra_pay;
    pbfa_pkg::t_status   r_status;
    logic [11:0]         r_roff;
    logic                r_copy;
    pbfa_pkg::t_res_item r_out;

    logic [SW-1:0]    v_start;
    logic [PW-1:0]    v_pay;
    logic [EW-1:0]    v_end;
    logic [PW-1:0]    size_w;
    logic [EW-1:0]    need;
    logic [EW-1:0]    ra_limit;
    logic [SW+PW-1:0] wr_data;
    logic [11:0]      roff_val;
    logic             inbuf;

    function automatic logic fits(input logic [EW-1:0] e, input logic [EW-1:0] lim,
                                  input logic [EW-1:0] nd);
        return (lim >= e) && ((lim - e) >= nd);
    endfunction

    // entry 0 is the head: start fixed at 0, payload held in r_head
    assign v_start = (i_idx == '0) ? '0 : r_rd[SW+PW-1:PW];
    assign v_pay   = (i_idx == '0) ? r_head : r_rd[PW-1:0];
    assign v_end   = (i_idx == '0 && r_head == '0) ? '0
                   : EW'(v_start) + EW'(HDR_BYTES) + EW'(v_pay);
    assign size_w   = PW'(r_req.req_size);
    assign need     = EW'(HDR_BYTES) + EW'(size_w);
    assign ra_limit = (i_idx < r_count) ? EW'(v_start) : EW'(BUF_BYTES);
    assign inbuf    = (r_req.target_offset != '0)
                   && (XW'(r_req.target_offset) <= XW'(BUF_BYTES - 1));

    always_comb begin
        o_st            = '0;
        o_st.req_type   = r_req.req_type;
        o_st.bad        = (r_req.req_size == '0)
                       || ({1'b0, r_req.req_size} > 17'(BUF_BYTES));
        o_st.tgt_zero   = (r_req.target_offset == '0);
        o_st.head_empty = (r_head == '0);
        o_st.loc_match  = (i_idx != '0 || r_head != '0)
                       && (XW'(v_start) + XW'(HDR_BYTES) == XW'(r_req.target_offset));
        o_st.gap_fit    = (i_idx != '0) && fits(r_prev_end, EW'(v_start), need);
        o_st.end_fit    = fits(r_prev_end, EW'(BUF_BYTES), need);
        o_st.ra_inplace = (r_ra_pay >= size_w) || fits(EW'(r_ra_st), ra_limit, need);
    end

    always_comb begin
        case (i_cmd.wsel)
            pbfa_pkg::WSEL_NEW: wr_data = {SW'(r_prev_end), size_w};
            pbfa_pkg::WSEL_PAY: wr_data = {r_ra_st, size_w};
            default:            wr_data = {v_start, v_pay};
        endcase
        case (i_cmd.roff_sel)
            pbfa_pkg::ROFF_HDR: roff_val = 12'(HDR_BYTES);
            pbfa_pkg::ROFF_NEW: roff_val = 12'(r_prev_end + EW'(HDR_BYTES));
            default:            roff_val = r_req.target_offset;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[i_wr_addr] <= wr_data;
        end
        r_rd <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= CW'(1);
        end else begin
            if (i_cmd.head_set) begin
                r_head <= size_w;
            end else if (i_cmd.head_clr) begin
                r_head <= '0;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req    <= i_in;
            r_status <= pbfa_pkg::ST_OK;
            r_roff   <= '0;
            r_copy   <= 1'b0;
        end
        if (i_cmd.prev_load) begin
            r_prev_end <= v_end;
        end
        if (i_cmd.ra_load) begin
            r_ra_st  <= v_start;
            r_ra_pay <= v_pay;
        end
        if (i_cmd.st_ld) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.roff_ld) begin
            r_roff <= roff_val;
        end
        if (i_cmd.copy_set) begin
            r_copy <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.status        <= r_status;
            r_out.result_offset <= (r_status == pbfa_pkg::ST_OK) ? r_roff : '0;
            r_out.copy_needed   <= r_copy;
            r_out.copy_source   <= r_copy ? r_req.target_offset : '0;
            r_out.in_buffer     <= (r_req.req_type == pbfa_pkg::REQ_CONTAINS) ? inbuf : 1'b0;
        end
    end

    assign o_count = r_count;
    assign o_out   = r_out;

endmodule

### hw/rtl/packet_buffer_first_fit_allocator.sv
// top level of the packet buffer first-fit allocator
// depends on pbfa_pkg, pbfa_ctl and pbfa_dp
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------
//  request  | in        | i_in_valid / o_in_ready   | i_in  (t_req_item)
//  result   | out       | o_out_valid / i_out_ready | o_out (t_res_item)
//
// one request at a time; the chunk table is walked one entry per cycle
// through a memory with one write port and one registered read port
// alloc, free and realloc walk the table; a contains query does not walk it
// reset empties the table (head entry cleared, count set to 1)
// a pending result in the output register does not block a new request;
// the next result waits in its final step until the output slot frees up
module packet_buffer_first_fit_allocator #(
    parameter int BUF_BYTES  = 4096,
    parameter int HDR_BYTES  = 6,
    parameter int MAX_CHUNKS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbfa_pkg::t_req_item i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbfa_pkg::t_res_item o_out
);

    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int IW = $clog2(MAX_CHUNKS);

    // command and status between sequencer and datapath
    pbfa_pkg::t_cmd  cmd;
    pbfa_pkg::t_stat st;
    logic [CW-1:0]   idx;
    logic [CW-1:0]   count;
    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   wr_addr;

    // sequencer: walks, shifts and transaction hand-off
    pbfa_ctl #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (st),
        .i_count     (count),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr)
    );

    // datapath: table memory, fit checks, result register
    pbfa_dp #(
        .BUF_BYTES  (BUF_BYTES),
        .HDR_BYTES  (HDR_BYTES),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cmd     (cmd),
        .i_idx     (idx),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_st      (st),
        .o_count   (count),
        .o_out     (o_out)
    );

endmodule

### hw/rtl/pbfa_checker.sv
// port-level checks for the packet buffer first-fit allocator
// depends on pbfa_pkg and the assertion macro header; bound to the top level
`include "packet_buffer_first_fit_allocator_macros.svh"

module pbfa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pbfa_pkg::t_res_item i_out
);

    // a stalled result stays put
    `PBFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out), "result changed while stalled")

    // status codes stay in their range
    `PBFA_ASSERT_NOW(a_status_range, i_clk, i_rst_n, i_out_valid, i_out.status <= 3'(pbfa_pkg::ST_TABLE_FULL), "status code out of range")

    // a failed request reports no offset and no copy
    `PBFA_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, i_out_valid && i_out.status != 3'(pbfa_pkg::ST_OK), i_out.result_offset == '0 && !i_out.copy_needed && !i_out.in_buffer, "failed transaction carries data")

    // a copy request comes only with a successful move to a new offset
    `PBFA_ASSERT_NOW(a_copy_ok, i_clk, i_rst_n, i_out_valid && i_out.copy_needed, i_out.status == 3'(pbfa_pkg::ST_OK) && i_out.copy_source != '0 && i_out.result_offset != i_out.copy_source, "bad copy request")

    // a query answer carries no offset
    `PBFA_ASSERT_NOW(a_query_clean, i_clk, i_rst_n, i_out_valid && i_out.in_buffer, i_out.result_offset == '0 && !i_out.copy_needed, "query result carries an offset")

endmodule

bind packet_buffer_first_fit_allocator pbfa_checker u_pbfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
